[rtl/osds_pkg.sv]
// types, codes and constants shared by the obstacle scan drive sequencer
`default_nettype none

package osds_pkg;

    // operation codes of an input word
    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_CMD    = 2'd1,
        OP_SAMPLE = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    // motor drive codes
    typedef enum logic [2:0] {
        DRV_STOP  = 3'd0,
        DRV_FWD   = 3'd1,
        DRV_BACK  = 3'd2,
        DRV_LEFT  = 3'd3,
        DRV_RIGHT = 3'd4
    } t_drive;

    // autonomous phases
    typedef enum logic [3:0] {
        PH_FORWARD    = 4'd0,
        PH_SCAN_STOP  = 4'd1,
        PH_SCAN_LEFT  = 4'd2,
        PH_SCAN_RIGHT = 4'd3,
        PH_DECIDE     = 4'd4,
        PH_BACKUP     = 4'd5,
        PH_TURN_LEFT  = 4'd6,
        PH_TURN_RIGHT = 4'd7,
        PH_RESUME     = 4'd8
    } t_phase;

    // ascii command bytes
    localparam logic [7:0] CMD_FWD    = 8'h46;
    localparam logic [7:0] CMD_BACK   = 8'h42;
    localparam logic [7:0] CMD_LEFT   = 8'h4C;
    localparam logic [7:0] CMD_RIGHT  = 8'h52;
    localparam logic [7:0] CMD_STOP   = 8'h53;
    localparam logic [7:0] CMD_AUTO   = 8'h41;
    localparam logic [7:0] CMD_MANUAL = 8'h4D;
    localparam logic [7:0] CMD_LOOK_L = 8'h31;
    localparam logic [7:0] CMD_LOOK_R = 8'h32;
    localparam logic [7:0] CMD_LOOK_C = 8'h33;

    // register indexes on the config port
    localparam logic [2:0] REG_SAFE_THRESHOLD = 3'd0;
    localparam logic [2:0] REG_DRIVE_SPEED    = 3'd1;
    localparam logic [2:0] REG_TURN_SPEED     = 3'd2;
    localparam logic [2:0] REG_CONFIRM_COUNT  = 3'd3;
    localparam logic [2:0] REG_TURN_TIME      = 3'd4;
    localparam logic [2:0] REG_BACKUP_TIME    = 3'd5;

    // register reset values
    localparam logic [13:0] SAFE_THRESHOLD_RST = 14'd200;
    localparam logic [7:0]  DRIVE_SPEED_RST    = 8'd230;
    localparam logic [7:0]  TURN_SPEED_RST     = 8'd230;
    localparam logic [3:0]  CONFIRM_COUNT_RST  = 4'd2;
    localparam logic [11:0] TURN_TIME_RST      = 12'd600;
    localparam logic [11:0] BACKUP_TIME_RST    = 12'd500;

    // servo angles and distances
    localparam logic [7:0]  ANGLE_LEFT   = 8'd150;
    localparam logic [7:0]  ANGLE_CENTER = 8'd90;
    localparam logic [7:0]  ANGLE_RIGHT  = 8'd30;
    localparam logic [13:0] NO_ECHO      = 14'd9990;

    // phase timing in milliseconds
    localparam logic [11:0] ELAPSED_MAX    = 12'd4095;
    localparam logic [11:0] SCAN_STOP_MS   = 12'd200;
    localparam logic [11:0] SCAN_LEFT_MS   = 12'd500;
    localparam logic [11:0] SCAN_RIGHT_MS  = 12'd700;
    localparam logic [11:0] DECIDE_MS      = 12'd300;
    localparam logic [11:0] RESUME_MS      = 12'd100;
    localparam logic [3:0]  CLOSE_MAX      = 4'd15;

    // configuration registers
    typedef struct packed {
        logic [13:0] safe_threshold;
        logic [7:0]  drive_speed;
        logic [7:0]  turn_speed;
        logic [3:0]  confirm_count;
        logic [11:0] turn_time;
        logic [11:0] backup_time;
    } t_cfg;

    // sequencer state
    typedef struct packed {
        logic        mode;
        t_phase      phase;
        logic [11:0] elapsed;
        logic [13:0] latest;
        logic [13:0] left_dist;
        logic [13:0] right_dist;
        logic [3:0]  close_count;
        t_drive      drive;
        logic [7:0]  duty;
        logic [7:0]  angle;
    } t_state;

    localparam t_state STATE_RST = '{
        mode:        1'b0,
        phase:       PH_FORWARD,
        elapsed:     12'd0,
        latest:      NO_ECHO,
        left_dist:   NO_ECHO,
        right_dist:  NO_ECHO,
        close_count: 4'd0,
        drive:       DRV_STOP,
        duty:        8'd0,
        angle:       ANGLE_CENTER
    };

endpackage

`default_nettype wire

[rtl/osds_step.sv]
// next-state logic for one word: tick, command or sample, then one auto pass
`default_nettype none

module osds_step
    import osds_pkg::*;
(
    input  t_state      i_state,
    input  t_cfg        i_cfg,
    input  logic [1:0]  i_operation,
    input  logic [7:0]  i_command_byte,
    input  logic [13:0] i_distance_tenths,
    output t_state      o_next,
    output logic        o_changed
);

    t_state s;
    t_op    op;
    logic   manual;
    logic   changed;

    always_comb begin
        s       = i_state;
        op      = t_op'(i_operation);
        manual  = ~i_state.mode;
        changed = 1'b0;

        // word specific update
        unique case (op)
            OP_TICK: begin
                if (s.elapsed != ELAPSED_MAX) s.elapsed = s.elapsed + 12'd1;
            end
            OP_CMD: begin
                case (i_command_byte)
                    CMD_FWD: begin
                        if (manual) begin s.drive = DRV_FWD; s.duty = i_cfg.drive_speed; end
                    end
                    CMD_BACK: begin
                        if (manual) begin s.drive = DRV_BACK; s.duty = i_cfg.drive_speed; end
                    end
                    CMD_LEFT: begin
                        if (manual) begin s.drive = DRV_LEFT; s.duty = i_cfg.turn_speed; end
                    end
                    CMD_RIGHT: begin
                        if (manual) begin s.drive = DRV_RIGHT; s.duty = i_cfg.turn_speed; end
                    end
                    CMD_STOP: begin
                        s.drive = DRV_STOP;
                        s.duty  = 8'd0;
                        s.angle = ANGLE_CENTER;
                        if (!manual) begin s.mode = 1'b0; changed = 1'b1; end
                    end
                    CMD_AUTO: begin
                        if (manual) begin
                            s.mode    = 1'b1;
                            s.phase   = PH_FORWARD;
                            s.elapsed = 12'd0;
                            changed   = 1'b1;
                        end
                    end
                    CMD_MANUAL: begin
                        if (!manual) begin
                            s.mode  = 1'b0;
                            s.drive = DRV_STOP;
                            s.duty  = 8'd0;
                            s.angle = ANGLE_CENTER;
                            changed = 1'b1;
                        end
                    end
                    CMD_LOOK_L: s.angle = ANGLE_LEFT;
                    CMD_LOOK_R: s.angle = ANGLE_RIGHT;
                    CMD_LOOK_C: s.angle = ANGLE_CENTER;
                    default: ;
                endcase
            end
            OP_SAMPLE: s.latest = i_distance_tenths;
            default: ;
        endcase

        // one pass of the autonomous sequence
        if (op != OP_NONE && s.mode) begin
            case (s.phase)
                PH_FORWARD: begin
                    s.drive = DRV_FWD;
                    s.duty  = i_cfg.drive_speed;
                    if (op == OP_SAMPLE) begin
                        if (s.latest < i_cfg.safe_threshold) begin
                            if (s.close_count != CLOSE_MAX) s.close_count = s.close_count + 4'd1;
                            if (s.close_count >= i_cfg.confirm_count) begin
                                s.drive       = DRV_STOP;
                                s.duty        = 8'd0;
                                s.phase       = PH_SCAN_STOP;
                                s.elapsed     = 12'd0;
                                s.close_count = 4'd0;
                            end
                        end else begin
                            s.close_count = 4'd0;
                        end
                    end
                end
                PH_SCAN_STOP: begin
                    if (s.elapsed >= SCAN_STOP_MS) begin
                        s.angle   = ANGLE_LEFT;
                        s.phase   = PH_SCAN_LEFT;
                        s.elapsed = 12'd0;
                    end
                end
                PH_SCAN_LEFT: begin
                    if (s.elapsed >= SCAN_LEFT_MS) begin
                        s.left_dist = s.latest;
                        s.angle     = ANGLE_RIGHT;
                        s.phase     = PH_SCAN_RIGHT;
                        s.elapsed   = 12'd0;
                    end
                end
                PH_SCAN_RIGHT: begin
                    if (s.elapsed >= SCAN_RIGHT_MS) begin
                        s.right_dist = s.latest;
                        s.angle      = ANGLE_CENTER;
                        s.phase      = PH_DECIDE;
                        s.elapsed    = 12'd0;
                    end
                end
                PH_DECIDE: begin
                    if (s.elapsed >= DECIDE_MS) begin
                        s.elapsed = 12'd0;
                        if (s.left_dist <= i_cfg.safe_threshold &&
                            s.right_dist <= i_cfg.safe_threshold) begin
                            s.drive = DRV_BACK;
                            s.duty  = i_cfg.drive_speed;
                            s.phase = PH_BACKUP;
                        end else if (s.left_dist > s.right_dist) begin
                            s.drive = DRV_LEFT;
                            s.duty  = i_cfg.turn_speed;
                            s.phase = PH_TURN_LEFT;
                        end else begin
                            s.drive = DRV_RIGHT;
                            s.duty  = i_cfg.turn_speed;
                            s.phase = PH_TURN_RIGHT;
                        end
                    end
                end
                PH_BACKUP: begin
                    if (s.elapsed >= i_cfg.backup_time) begin
                        s.drive   = DRV_RIGHT;
                        s.duty    = i_cfg.turn_speed;
                        s.phase   = PH_TURN_RIGHT;
                        s.elapsed = 12'd0;
                    end
                end
                PH_TURN_LEFT, PH_TURN_RIGHT: begin
                    if (s.elapsed >= i_cfg.turn_time) begin
                        s.drive   = DRV_STOP;
                        s.duty    = 8'd0;
                        s.phase   = PH_RESUME;
                        s.elapsed = 12'd0;
                    end
                end
                PH_RESUME: begin
                    if (s.elapsed >= RESUME_MS) begin
                        s.drive   = DRV_FWD;
                        s.duty    = i_cfg.drive_speed;
                        s.phase   = PH_FORWARD;
                        s.elapsed = 12'd0;
                    end
                end
                default: begin
                    s.phase   = PH_FORWARD;
                    s.elapsed = 12'd0;
                end
            endcase
        end

        o_next    = s;
        o_changed = changed;
    end

endmodule

`default_nettype wire

[rtl/obstacle_scan_drive_sequencer_top.sv]
// top level: config registers, sequencer state and registered result word
//
//  channel   direction  handshake                  payload
//  input     in         i_in_valid / o_in_stall    operation, command_byte, distance_tenths
//  output    out        o_out_valid / i_out_stall  drive_command, drive_duty, servo_angle,
//                                                  auto_mode, auto_phase, mode_changed
//  config    in         psel / penable / pready    paddr, pwdata, prdata
//
// one word per cycle while the output side does not stall; the result shows in the cycle after the input word is taken
// the state update is a single combinational pass between the state and result registers
// synchronous active-low reset returns config registers, state and output valid to their defaults
// input stalls only while a result is held and the output side stalls
`default_nettype none

module obstacle_scan_drive_sequencer_top
    import osds_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input words
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_operation,
    input  logic [7:0]  i_command_byte,
    input  logic [13:0] i_distance_tenths,
    // result words
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_drive_command,
    output logic [7:0]  o_drive_duty,
    output logic [7:0]  o_servo_angle,
    output logic        o_auto_mode,
    output logic [3:0]  o_auto_phase,
    output logic        o_mode_changed,
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg   r_cfg;
    t_state r_state;
    t_state w_next;
    logic   w_changed;
    logic   w_accept;
    logic   w_cfg_wr;
    logic   r_out_valid;
    logic   n_out_valid;
    logic [2:0] w_reg_idx;

    logic [2:0] r_drive_command;
    logic [7:0] r_drive_duty;
    logic [7:0] r_servo_angle;
    logic       r_auto_mode;
    logic [3:0] r_auto_phase;
    logic       r_mode_changed;

    // handshake
    assign o_in_stall  = r_out_valid & i_out_stall;
    assign w_accept    = i_in_valid & ~o_in_stall;
    assign n_out_valid = w_accept | (r_out_valid & i_out_stall);

    // config port decode
    assign pready    = 1'b1;
    assign w_reg_idx = paddr[4:2];
    assign w_cfg_wr  = psel & penable & pwrite & pready;

    always_comb begin
        unique case (w_reg_idx)
            REG_SAFE_THRESHOLD: prdata = {18'd0, r_cfg.safe_threshold};
            REG_DRIVE_SPEED:    prdata = {24'd0, r_cfg.drive_speed};
            REG_TURN_SPEED:     prdata = {24'd0, r_cfg.turn_speed};
            REG_CONFIRM_COUNT:  prdata = {28'd0, r_cfg.confirm_count};
            REG_TURN_TIME:      prdata = {20'd0, r_cfg.turn_time};
            REG_BACKUP_TIME:    prdata = {20'd0, r_cfg.backup_time};
            default:            prdata = 32'd0;
        endcase
    end

    // next-state logic
    osds_step u_step (
        .i_state           (r_state),
        .i_cfg             (r_cfg),
        .i_operation       (i_operation),
        .i_command_byte    (i_command_byte),
        .i_distance_tenths (i_distance_tenths),
        .o_next            (w_next),
        .o_changed         (w_changed)
    );

    // config, state and output valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.safe_threshold <= SAFE_THRESHOLD_RST;
            r_cfg.drive_speed    <= DRIVE_SPEED_RST;
            r_cfg.turn_speed     <= TURN_SPEED_RST;
            r_cfg.confirm_count  <= CONFIRM_COUNT_RST;
            r_cfg.turn_time      <= TURN_TIME_RST;
            r_cfg.backup_time    <= BACKUP_TIME_RST;
            r_state              <= STATE_RST;
            r_out_valid          <= 1'b0;
        end else begin
            if (w_cfg_wr) begin
                unique case (w_reg_idx)
                    REG_SAFE_THRESHOLD: r_cfg.safe_threshold <= pwdata[13:0];
                    REG_DRIVE_SPEED:    r_cfg.drive_speed    <= pwdata[7:0];
                    REG_TURN_SPEED:     r_cfg.turn_speed     <= pwdata[7:0];
                    REG_CONFIRM_COUNT:  r_cfg.confirm_count  <= pwdata[3:0];
                    REG_TURN_TIME:      r_cfg.turn_time      <= pwdata[11:0];
                    REG_BACKUP_TIME:    r_cfg.backup_time    <= pwdata[11:0];
                    default: ;
                endcase
            end
            if (w_accept) r_state <= w_next;
            r_out_valid <= n_out_valid;
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_drive_command <= w_next.drive;
            r_drive_duty    <= w_next.duty;
            r_servo_angle   <= w_next.angle;
            r_auto_mode     <= w_next.mode;
            r_auto_phase    <= w_next.phase;
            r_mode_changed  <= w_changed;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_drive_command = r_drive_command;
    assign o_drive_duty    = r_drive_duty;
    assign o_servo_angle   = r_servo_angle;
    assign o_auto_mode     = r_auto_mode;
    assign o_auto_phase    = r_auto_phase;
    assign o_mode_changed  = r_mode_changed;

    // a free output register never pushes back on the input
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_out_valid && i_out_stall) |-> !o_in_stall)
        else $error("input stalled while output register free");

    // stopped motors always carry zero duty
    a_stop_zero_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.drive == DRV_STOP |-> r_state.duty == 8'd0)
        else $error("stop drive with nonzero duty");

    // while scanning in auto mode the motors stay stopped
    a_scan_stopped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.mode && (r_state.phase == PH_SCAN_STOP || r_state.phase == PH_SCAN_LEFT ||
         r_state.phase == PH_SCAN_RIGHT || r_state.phase == PH_DECIDE))
        |-> r_state.drive == DRV_STOP)
        else $error("motors running during scan");

    // a reported mode change matches a flip of the mode flag
    a_mode_flip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_changed) |-> w_next.mode != r_state.mode)
        else $error("mode change flagged without mode flip");

endmodule

`default_nettype wire

[test/tb_top.sv]
// self-checking testbench for the obstacle scan drive sequencer, predicted words checked in order
module tb_top;
    import osds_pkg::*;

    localparam int HALF_PERIOD  = 10;
    localparam int RESET_CYCLES = 9;
    localparam int HOLD_CYCLES  = 80;
    localparam int IDLE_LIMIT   = 1000;
    localparam int NON_TICK_MIN = 240;
    localparam int PICK_KEEP    = 7;    // commands that never leave auto mode
    localparam int PICK_ANY     = 9;
    localparam logic [13:0] DIST_TOP = 14'h3FFF;

    // one result word as the block reports it
    typedef struct packed {
        t_drive      drive;
        logic [7:0]  duty;
        logic [7:0]  angle;
        logic        auto_on;
        t_phase      phase;
        logic        changed;
    } t_result;

    typedef enum {STALL_NONE, STALL_LIGHT, STALL_TOGGLE, STALL_HEAVY, STALL_HOLD} t_stall_mode;

    // predictor of the sequencer plus the queue of words still awaited
    class drive_scoreboard;
        logic [13:0] safe_thr;
        logic [7:0]  fwd_duty;
        logic [7:0]  turn_duty;
        logic [3:0]  confirm_need;
        logic [11:0] turn_ms;
        logic [11:0] backup_ms;
        logic        auto_on;
        t_phase      phase;
        logic [11:0] elapsed;
        logic [13:0] latest;
        logic [13:0] left_seen;
        logic [13:0] right_seen;
        logic [3:0]  close_run;
        t_drive      drive;
        logic [7:0]  duty;
        logic [7:0]  angle;
        int          errors;
        int          trips_done;
        t_result     awaited[$];

        function new();
            safe_thr     = SAFE_THRESHOLD_RST;
            fwd_duty     = DRIVE_SPEED_RST;
            turn_duty    = TURN_SPEED_RST;
            confirm_need = CONFIRM_COUNT_RST;
            turn_ms      = TURN_TIME_RST;
            backup_ms    = BACKUP_TIME_RST;
            auto_on      = 1'b0;
            phase        = PH_FORWARD;
            elapsed      = '0;
            latest       = NO_ECHO;
            left_seen    = NO_ECHO;
            right_seen   = NO_ECHO;
            close_run    = '0;
            drive        = DRV_STOP;
            duty         = 8'd0;
            angle        = ANGLE_CENTER;
            errors       = 0;
            trips_done   = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] value);
            case (idx)
                REG_SAFE_THRESHOLD: safe_thr = value[13:0];
                REG_DRIVE_SPEED:    fwd_duty = value[7:0];
                REG_TURN_SPEED:     turn_duty = value[7:0];
                REG_CONFIRM_COUNT:  confirm_need = value[3:0];
                REG_TURN_TIME:      turn_ms = value[11:0];
                REG_BACKUP_TIME:    backup_ms = value[11:0];
                default: ;
            endcase
        endfunction

        function void drive_to(t_drive d, logic [7:0] pwm);
            drive = d;
            duty  = pwm;
        endfunction

        function void enter_phase(t_phase p);
            phase   = p;
            elapsed = '0;
        endfunction

        // advance the copy by one accepted input word and queue its result
        function void note_input(t_op op, logic [7:0] cmd, logic [13:0] dist_tenths);
            logic    changed;
            logic    manual;
            t_result r;
            changed = 1'b0;
            manual  = ~auto_on;
            if (op != OP_NONE) begin
                case (op)
                    OP_TICK: if (elapsed < ELAPSED_MAX) elapsed = elapsed + 1'b1;
                    OP_SAMPLE: latest = dist_tenths;
                    default: begin
                        case (cmd)
                            CMD_FWD:   if (manual) drive_to(DRV_FWD, fwd_duty);
                            CMD_BACK:  if (manual) drive_to(DRV_BACK, fwd_duty);
                            CMD_LEFT:  if (manual) drive_to(DRV_LEFT, turn_duty);
                            CMD_RIGHT: if (manual) drive_to(DRV_RIGHT, turn_duty);
                            CMD_STOP: begin
                                drive_to(DRV_STOP, 8'd0);
                                angle = ANGLE_CENTER;
                                if (!manual) begin
                                    auto_on = 1'b0;
                                    changed = 1'b1;
                                end
                            end
                            CMD_AUTO: if (manual) begin
                                auto_on = 1'b1;
                                enter_phase(PH_FORWARD);
                                changed = 1'b1;
                            end
                            CMD_MANUAL: if (!manual) begin
                                auto_on = 1'b0;
                                drive_to(DRV_STOP, 8'd0);
                                angle = ANGLE_CENTER;
                                changed = 1'b1;
                            end
                            CMD_LOOK_L: angle = ANGLE_LEFT;
                            CMD_LOOK_R: angle = ANGLE_RIGHT;
                            CMD_LOOK_C: angle = ANGLE_CENTER;
                            default: ;
                        endcase
                    end
                endcase

                // one pass of the autonomous sequence
                if (auto_on) begin
                    case (phase)
                        PH_FORWARD: begin
                            drive_to(DRV_FWD, fwd_duty);
                            if (op == OP_SAMPLE) begin
                                if (latest < safe_thr) begin
                                    if (close_run < CLOSE_MAX) close_run = close_run + 1'b1;
                                    if (close_run >= confirm_need) begin
                                        drive_to(DRV_STOP, 8'd0);
                                        enter_phase(PH_SCAN_STOP);
                                        close_run = '0;
                                    end
                                end else begin
                                    close_run = '0;
                                end
                            end
                        end
                        PH_SCAN_STOP: if (elapsed >= SCAN_STOP_MS) begin
                            angle = ANGLE_LEFT;
                            enter_phase(PH_SCAN_LEFT);
                        end
                        PH_SCAN_LEFT: if (elapsed >= SCAN_LEFT_MS) begin
                            left_seen = latest;
                            angle = ANGLE_RIGHT;
                            enter_phase(PH_SCAN_RIGHT);
                        end
                        PH_SCAN_RIGHT: if (elapsed >= SCAN_RIGHT_MS) begin
                            right_seen = latest;
                            angle = ANGLE_CENTER;
                            enter_phase(PH_DECIDE);
                        end
                        PH_DECIDE: if (elapsed >= DECIDE_MS) begin
                            // both sides blocked backs up, else turn toward the larger gap
                            if (left_seen <= safe_thr && right_seen <= safe_thr) begin
                                drive_to(DRV_BACK, fwd_duty);
                                enter_phase(PH_BACKUP);
                            end else if (left_seen > right_seen) begin
                                drive_to(DRV_LEFT, turn_duty);
                                enter_phase(PH_TURN_LEFT);
                            end else begin
                                drive_to(DRV_RIGHT, turn_duty);
                                enter_phase(PH_TURN_RIGHT);
                            end
                        end
                        PH_BACKUP: if (elapsed >= backup_ms) begin
                            drive_to(DRV_RIGHT, turn_duty);
                            enter_phase(PH_TURN_RIGHT);
                        end
                        PH_TURN_LEFT, PH_TURN_RIGHT: if (elapsed >= turn_ms) begin
                            drive_to(DRV_STOP, 8'd0);
                            enter_phase(PH_RESUME);
                        end
                        PH_RESUME: if (elapsed >= RESUME_MS) begin
                            enter_phase(PH_FORWARD);
                            drive_to(DRV_FWD, fwd_duty);
                            trips_done++;
                        end
                        default: enter_phase(PH_FORWARD);
                    endcase
                end
            end
            r = '{drive, duty, angle, auto_on, phase, changed};
            awaited.push_back(r);
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            end
        endfunction

        // match one result word against the oldest prediction
        function void check_result(t_result got);
            t_result want;
            if (awaited.size() == 0) begin
                errors++;
                $display("%0t: result word with none awaited, got drive %0d duty %0d angle %0d",
                         $time, got.drive, got.duty, got.angle);
                return;
            end
            want = awaited.pop_front();
            compare_field("drive_command", 16'(want.drive), 16'(got.drive));
            compare_field("drive_duty", 16'(want.duty), 16'(got.duty));
            compare_field("servo_angle", 16'(want.angle), 16'(got.angle));
            compare_field("auto_mode", 16'(want.auto_on), 16'(got.auto_on));
            compare_field("auto_phase", 16'(want.phase), 16'(got.phase));
            compare_field("mode_changed", 16'(want.changed), 16'(got.changed));
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_operation;
    logic [7:0]  i_command_byte;
    logic [13:0] i_distance_tenths;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [2:0]  o_drive_command;
    logic [7:0]  o_drive_duty;
    logic [7:0]  o_servo_angle;
    logic        o_auto_mode;
    logic [3:0]  o_auto_phase;
    logic        o_mode_changed;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    drive_scoreboard sb = new();
    bit hold_request = 1'b0;
    int quiet_cycles = 0;

    obstacle_scan_drive_sequencer_top DUT (.*);

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // result words taken at the rising edge
    always @(posedge i_clk) begin : result_monitor
        t_result seen;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen = '{t_drive'(o_drive_command), o_drive_duty, o_servo_angle, o_auto_mode,
                     t_phase'(o_auto_phase), o_mode_changed};
            sb.check_result(seen);
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // receiver stall pattern, with a long hold-off on request
    initial begin
        t_stall_mode mode;
        int          span;
        i_out_stall = 1'b0;
        forever begin
            mode = t_stall_mode'($urandom_range(0, 3));
            span = $urandom_range(5, 60);
            if (hold_request) begin
                mode = STALL_HOLD;
                span = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            repeat (span) begin
                @(negedge i_clk);
                case (mode)
                    STALL_NONE:   i_out_stall <= 1'b0;
                    STALL_LIGHT:  i_out_stall <= ($urandom_range(0, 99) < 30);
                    STALL_TOGGLE: i_out_stall <= ~i_out_stall;
                    STALL_HEAVY:  i_out_stall <= ($urandom_range(0, 99) < 75);
                    default:      i_out_stall <= 1'b1;
                endcase
            end
        end
    end

    function automatic logic [7:0] pick_command(int top);
        case ($urandom_range(0, top))
            0: return CMD_FWD;
            1: return CMD_BACK;
            2: return CMD_LEFT;
            3: return CMD_RIGHT;
            4: return CMD_LOOK_L;
            5: return CMD_LOOK_R;
            6: return CMD_LOOK_C;
            7: return CMD_AUTO;
            8: return CMD_STOP;
            default: return CMD_MANUAL;
        endcase
    endfunction

    // offer one input word and hold it until taken
    task automatic send_word(t_op op, logic [7:0] cmd, logic [13:0] dist_tenths);
        @(negedge i_clk);
        i_in_valid        <= 1'b1;
        i_operation       <= op;
        i_command_byte    <= cmd;
        i_distance_tenths <= dist_tenths;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(op, cmd, dist_tenths);
    endtask

    task automatic pause_input(int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
    endtask

    // wait until every predicted word has come back
    task automatic drain_results();
        pause_input(1);
        while (sb.awaited.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // setup and access phase of one register write
    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(idx, value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_setting(logic [13:0] thr, logic [7:0] fwd, logic [7:0] turn,
                                 logic [3:0] need, logic [11:0] turn_t, logic [11:0] back_t);
        drain_results();
        write_reg(REG_SAFE_THRESHOLD, 32'(thr));
        write_reg(REG_DRIVE_SPEED, 32'(fwd));
        write_reg(REG_TURN_SPEED, 32'(turn));
        write_reg(REG_CONFIRM_COUNT, 32'(need));
        write_reg(REG_TURN_TIME, 32'(turn_t));
        write_reg(REG_BACKUP_TIME, 32'(back_t));
    endtask

    // random words steered by the predicted phase so scans run to the end
    task automatic random_run(int item_cap);
        int          sent;
        int          non_tick;
        int          trips_at_start;
        int          roll;
        int          burst;
        bit          hold_asked;
        t_op         op;
        logic [7:0]  cmd;
        logic [13:0] dist_tenths;
        sent = 0;
        non_tick = 0;
        trips_at_start = sb.trips_done;
        burst = 0;
        hold_asked = 1'b0;
        while (sent < item_cap && (non_tick < NON_TICK_MIN || sb.trips_done == trips_at_start))
        begin
            // sender bursts with gaps between them
            if (burst == 0) begin
                if ($urandom_range(0, 3) != 0) pause_input($urandom_range(1, 12));
                burst = $urandom_range(1, 60);
            end
            burst--;
            if (!hold_asked && sent == 30) begin
                hold_request = 1'b1;
                hold_asked = 1'b1;
            end

            cmd         = 8'($urandom_range(0, 255));
            dist_tenths = 14'($urandom_range(0, DIST_TOP));
            roll        = $urandom_range(0, 999);
            op          = OP_TICK;
            if (!sb.auto_on) begin
                if (roll < 40) begin
                    op = OP_CMD;
                    cmd = CMD_AUTO;
                end else if (roll < 350) begin
                    op = OP_CMD;
                    if (roll < 290) cmd = pick_command(PICK_ANY);
                end else if (roll < 600) begin
                    op = OP_SAMPLE;
                end else if (roll >= 960) begin
                    op = OP_NONE;
                end
            end else if (sb.phase == PH_FORWARD) begin
                if (roll < 4) begin
                    op = OP_CMD;
                    cmd = roll[0] ? CMD_STOP : CMD_MANUAL;
                end else if (roll < 60) begin
                    op = OP_CMD;
                    cmd = pick_command(PICK_KEEP);
                end else if (roll < 800) begin
                    op = OP_SAMPLE;
                    if (roll < 730 && sb.safe_thr != 0)
                        dist_tenths = 14'($urandom_range(0, sb.safe_thr - 1));
                end else if (roll >= 990) begin
                    op = OP_NONE;
                end
            end else begin
                // timed phases mostly need ticks
                if (roll == 0 && $urandom_range(0, 9) == 0) begin
                    op = OP_CMD;
                    cmd = $urandom_range(0, 1) ? CMD_STOP : CMD_MANUAL;
                end else if (roll < 10) begin
                    op = OP_CMD;
                    cmd = pick_command(PICK_KEEP);
                end else if (roll < 40) begin
                    op = OP_SAMPLE;
                    if (roll < 25) dist_tenths = 14'($urandom_range(0, sb.safe_thr));
                end else if (roll >= 996) begin
                    op = OP_NONE;
                end
            end
            send_word(op, cmd, dist_tenths);
            sent++;
            if (op != OP_TICK) non_tick++;
        end
    endtask

    initial begin
        i_rst_n           = 1'b0;
        i_in_valid        = 1'b0;
        i_operation       = OP_TICK;
        i_command_byte    = 8'd0;
        i_distance_tenths = 14'd0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = 5'd0;
        pwdata            = 32'd0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed words at reset settings
        send_word(OP_TICK, 8'h00, 14'd0);
        send_word(OP_NONE, 8'hFF, DIST_TOP);
        send_word(OP_CMD, CMD_FWD, 14'd0);
        send_word(OP_CMD, CMD_BACK, 14'd0);
        send_word(OP_CMD, CMD_LEFT, 14'd0);
        send_word(OP_CMD, CMD_RIGHT, 14'd0);
        send_word(OP_CMD, CMD_LOOK_L, 14'd0);
        send_word(OP_CMD, CMD_LOOK_R, 14'd0);
        send_word(OP_CMD, CMD_LOOK_C, 14'd0);
        send_word(OP_CMD, 8'h00, DIST_TOP);
        send_word(OP_CMD, 8'hFF, 14'd0);
        send_word(OP_CMD, CMD_STOP, 14'd0);
        send_word(OP_SAMPLE, 8'h00, 14'd0);
        send_word(OP_SAMPLE, 8'hFF, DIST_TOP);
        send_word(OP_SAMPLE, 8'h00, NO_ECHO);
        send_word(OP_CMD, CMD_AUTO, 14'd0);
        send_word(OP_CMD, CMD_FWD, 14'd0);
        send_word(OP_CMD, CMD_AUTO, 14'd0);
        send_word(OP_SAMPLE, 8'h00, 14'd150);
        send_word(OP_SAMPLE, 8'h00, NO_ECHO);
        send_word(OP_SAMPLE, 8'h00, 14'd0);
        send_word(OP_SAMPLE, 8'h00, 14'd199);
        send_word(OP_TICK, 8'h00, 14'd0);
        send_word(OP_CMD, CMD_MANUAL, 14'd0);
        send_word(OP_CMD, CMD_AUTO, 14'd0);
        send_word(OP_CMD, CMD_STOP, 14'd0);

        // random words over several register settings, extremes among them
        apply_setting(14'($urandom_range(100, 1500)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 4'($urandom_range(1, 4)),
                      12'($urandom_range(1, 300)), 12'($urandom_range(1, 300)));
        random_run(500);
        apply_setting(NO_ECHO, 8'd0, 8'd255, 4'd0, 12'd0, 12'd0);
        random_run(100);
        apply_setting(14'd1, 8'd255, 8'd0, 4'd15, 12'd4095, 12'd1);
        random_run(120);
        apply_setting(14'd0, 8'd128, 8'd64, 4'd1, 12'd1, 12'd4095);
        random_run(60);
        apply_setting(14'($urandom_range(300, 3000)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 4'($urandom_range(1, 6)),
                      12'($urandom_range(1, 400)), 12'($urandom_range(1, 400)));
        random_run(150);

        drain_results();
        if (sb.errors == 0 && sb.awaited.size() == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
